// ----- rtl/core/wsc_pkg.sv -----
package wsc_pkg;

   localparam int NUM_CHAN = 2;
   localparam int CHAN_WHEEL = 0;
   localparam int CHAN_CRANK = 1;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_WHEEL_CIRC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STALE_EVENTS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_LIMIT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CADENCE_LIMIT = 2'd3;

   localparam logic [11:0] RST_WHEEL_CIRC = 12'd2130;
   localparam logic [5:0] RST_STALE_EVENTS = 6'd30;
   localparam logic [7:0] RST_SPEED_LIMIT = 8'd120;
   localparam logic [7:0] RST_CADENCE_LIMIT = 8'd120;

   // 1024*36 = 9 << 12, 1024*60 = 15 << 12
   localparam logic [3:0] SPEED_MUL = 4'd9;
   localparam logic [3:0] CADENCE_MUL = 4'd15;
   localparam int UNIT_SHIFT = 12;
   localparam logic [13:0] SPEED_DEN = 14'd10000;

   localparam int NUM_W = 44;
   localparam int DEN_W = 30;

   typedef struct packed {
      logic [11:0] wheel_circumference_mm;
      logic [5:0] stale_events;
      logic [7:0] speed_limit_kph;
      logic [7:0] cadence_limit_rpm;
   } cfg_type;

   typedef struct packed {
      logic changed;
      logic stale;
      logic [15:0] drev;
      logic [15:0] dtime;
   } chan_cmd_type;

   typedef struct packed {
      chan_cmd_type crank;
      chan_cmd_type wheel;
   } cmd_type;

endpackage

// ----- rtl/core/wsc_front.sv -----
module wsc_front (
   input logic clock,
   input logic reset,
   input wsc_pkg::cfg_type cfg,
   input logic accept,
   input logic [15:0] wheel_rev_count,
   input logic [15:0] wheel_event_time,
   input logic [15:0] crank_rev_count,
   input logic [15:0] crank_event_time,
   output wsc_pkg::cmd_type cmd
);
   import wsc_pkg::*;

   logic [15:0] prev_count_ff [NUM_CHAN];
   logic [15:0] prev_time_ff [NUM_CHAN];
   logic [31:0] total_ff [NUM_CHAN];
   logic [31:0] snap_ff [NUM_CHAN];
   logic [5:0] item_cnt_ff [NUM_CHAN];

   logic [15:0] prev_count_in [NUM_CHAN];
   logic [15:0] prev_time_in [NUM_CHAN];
   logic [31:0] total_in [NUM_CHAN];
   logic [31:0] snap_in [NUM_CHAN];
   logic [5:0] item_cnt_in [NUM_CHAN];

   logic [15:0] count_arr [NUM_CHAN];
   logic [15:0] time_arr [NUM_CHAN];
   chan_cmd_type ccmd [NUM_CHAN];

   assign count_arr[CHAN_WHEEL] = wheel_rev_count;
   assign time_arr[CHAN_WHEEL] = wheel_event_time;
   assign count_arr[CHAN_CRANK] = crank_rev_count;
   assign time_arr[CHAN_CRANK] = crank_event_time;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (item_cnt_ff[i] == cfg.stale_events) begin
            snap_in[i] = total_ff[i];
            item_cnt_in[i] = '0;
         end else begin
            snap_in[i] = snap_ff[i];
            item_cnt_in[i] = item_cnt_ff[i] + 6'd1;
         end
         ccmd[i].changed = (count_arr[i] != prev_count_ff[i]);
         ccmd[i].drev = count_arr[i] - prev_count_ff[i];
         ccmd[i].dtime = time_arr[i] - prev_time_ff[i];
         if (ccmd[i].changed) begin
            total_in[i] = total_ff[i] + {16'd0, ccmd[i].drev};
            prev_count_in[i] = count_arr[i];
            prev_time_in[i] = time_arr[i];
         end else begin
            total_in[i] = total_ff[i];
            prev_count_in[i] = prev_count_ff[i];
            prev_time_in[i] = prev_time_ff[i];
         end
         ccmd[i].stale = (snap_in[i] == total_in[i]) && (total_in[i] != '0);
      end
   end

   assign cmd.wheel = ccmd[CHAN_WHEEL];
   assign cmd.crank = ccmd[CHAN_CRANK];

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (reset) begin
            prev_count_ff[i] <= '0;
            prev_time_ff[i] <= '0;
            total_ff[i] <= '0;
            snap_ff[i] <= '0;
            item_cnt_ff[i] <= '0;
         end else if (accept) begin
            prev_count_ff[i] <= prev_count_in[i];
            prev_time_ff[i] <= prev_time_in[i];
            total_ff[i] <= total_in[i];
            snap_ff[i] <= snap_in[i];
            item_cnt_ff[i] <= item_cnt_in[i];
         end
      end
   end

endmodule

// ----- rtl/core/wsc_queue.sv -----
module wsc_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input wsc_pkg::cmd_type push_data,
   input logic pop,
   output wsc_pkg::cmd_type pop_data,
   output logic full,
   output logic empty
);
   import wsc_pkg::*;

   cmd_type entry_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ----- rtl/core/wsc_back.sv -----
module wsc_back (
   input logic clock,
   input logic reset,
   input wsc_pkg::cfg_type cfg,
   input logic q_empty,
   input wsc_pkg::cmd_type q_data,
   output logic q_pop,
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [15:0] rsp_tdata
);
   import wsc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL = 3'd1;
   localparam logic [2:0] ST_CMP = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_FIN = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic ch_ff, ch_in;
   cmd_type cmd_ff, cmd_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [7:0] quo_ff, quo_in;
   logic ovf_ff, ovf_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] held_ff [NUM_CHAN];
   logic [7:0] held_in [NUM_CHAN];
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   chan_cmd_type cur;
   logic [7:0] limit;
   logic [15:0] circ9;
   logic [31:0] prod;
   logic [7:0] val;

   assign cur = ch_ff ? cmd_ff.crank : cmd_ff.wheel;
   assign limit = ch_ff ? cfg.cadence_limit_rpm : cfg.speed_limit_kph;
   assign circ9 = {4'd0, cfg.wheel_circumference_mm} * {12'd0, SPEED_MUL};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      cmd_in = cmd_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      step_in = step_ff;
      held_in = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      q_pop = 1'b0;
      prod = '0;
      val = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cmd_in = q_data;
               ch_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (ch_ff) begin
               prod = {16'd0, cur.drev} * {28'd0, CADENCE_MUL};
               den_in = {14'd0, cur.dtime};
            end else begin
               prod = {16'd0, circ9} * {16'd0, cur.drev};
               den_in = DEN_W'({14'd0, cur.dtime} * {16'd0, SPEED_DEN});
            end
            num_in = {prod, UNIT_SHIFT'(0)};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            ovf_in = (num_ff >= {6'd0, den_ff, 8'd0});
            rem_in = num_ff;
            dsh_in = {7'd0, den_ff, 7'd0};
            quo_in = '0;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               quo_in = {quo_ff[6:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            val = held_ff[ch_ff];
            if (cur.changed) begin
               val = (cur.dtime == '0 || ovf_ff) ? 8'd0 : quo_ff;
            end
            if (cur.stale || val > limit) begin
               val = 8'd0;
            end
            held_in[ch_ff] = val;
            if (ch_ff) begin
               state_in = ST_OUT;
            end else begin
               ch_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {held_ff[CHAN_CRANK], held_ff[CHAN_WHEEL]};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      step_ff <= step_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ch_ff <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff <= held_in;
      end
   end

endmodule

// ----- rtl/core/wheel_speed_and_cadence_calc.sv -----
// Wheel speed (kph) and crank cadence (rpm) from cumulative 16-bit revolution
// counts and 1/1024 s event times. A beat on req is taken whenever the two-entry
// command queue has room; the front end updates the per-channel counts, totals
// and stall snapshots in that same cycle, so up to three beats are taken back to
// back when the back end is idle (one popped at once, two held in the queue).
// The back end then works each beat through one shared 8-step restoring
// divider, wheel channel first, then crank, and finishes one beat before it
// pops the next. Results leave through an output register, so the back end
// starts the next beat while a result waits.
// Configuration writes take effect on the next clock edge and belong to idle time.
module wheel_speed_and_cadence_calc (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // wheel_rev_count, wheel_event_time, crank_rev_count, crank_event_time
   input logic [63:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // speed_kph, cadence_rpm
   output logic [15:0] rsp_tdata,
   input logic csr_we,
   input logic [wsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [wsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wsc_pkg::*;

   cfg_type cfg_ff;
   cmd_type fe_cmd;
   cmd_type q_data;
   logic q_full;
   logic q_empty;
   logic q_pop;
   logic accept;

   assign req_tready = !q_full;
   assign accept = req_tvalid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_circumference_mm <= RST_WHEEL_CIRC;
         cfg_ff.stale_events <= RST_STALE_EVENTS;
         cfg_ff.speed_limit_kph <= RST_SPEED_LIMIT;
         cfg_ff.cadence_limit_rpm <= RST_CADENCE_LIMIT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WHEEL_CIRC: cfg_ff.wheel_circumference_mm <= csr_wdata;
            CSR_STALE_EVENTS: cfg_ff.stale_events <= csr_wdata[5:0];
            CSR_SPEED_LIMIT: cfg_ff.speed_limit_kph <= csr_wdata[7:0];
            CSR_CADENCE_LIMIT: cfg_ff.cadence_limit_rpm <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   wsc_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .accept(accept),
      .wheel_rev_count(req_tdata[15:0]),
      .wheel_event_time(req_tdata[31:16]),
      .crank_rev_count(req_tdata[47:32]),
      .crank_event_time(req_tdata[63:48]),
      .cmd(fe_cmd)
   );

   wsc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(accept),
      .push_data(fe_cmd),
      .pop(q_pop),
      .pop_data(q_data),
      .full(q_full),
      .empty(q_empty)
   );

   wsc_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(q_empty),
      .q_data(q_data),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule

// ----- tb/sv/wsc_reading_checker.sv -----
`timescale 1ns / 1ps
module wsc_reading_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   // wheel_rev_count, wheel_event_time, crank_rev_count, crank_event_time
   input logic [63:0] req_tdata,
   input logic rsp_tvalid,
   input logic rsp_tready,
   // speed_kph, cadence_rpm
   input logic [15:0] rsp_tdata,
   input logic csr_we,
   input logic [wsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [wsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int mismatch_count,
   output int pending_count
);
   import wsc_pkg::*;

   // 1024 * 36 and 1024 * 60
   localparam logic [63:0] SPEED_SCALE = 64'd36864;
   localparam logic [63:0] SPEED_DIVISOR = 64'd10000;
   localparam logic [63:0] CADENCE_SCALE = 64'd61440;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [15:0] prev_count;
      logic [15:0] prev_time;
      logic [31:0] total_revs;
      logic [31:0] snapshot_revs;
      logic [5:0] event_counter;
      logic [7:0] held_value;
   } revs_state_type;

   typedef struct packed {
      logic [7:0] cadence_rpm;
      logic [7:0] speed_kph;
   } reading_type;

   cfg_type cfg;
   revs_state_type chan_state [NUM_CHAN];
   reading_type expected_readings [$];
   int fail_tally;

   function automatic logic [7:0] advance_channel(input int ch, input logic [15:0] count,
                                                  input logic [15:0] ev_time);
      revs_state_type st;
      logic [63:0] drev;
      logic [63:0] dtime;
      logic [63:0] value;
      logic [7:0] limit;
      st = chan_state[ch];
      limit = (ch == CHAN_WHEEL) ? cfg.speed_limit_kph : cfg.cadence_limit_rpm;
      if (st.event_counter == cfg.stale_events) begin
         st.snapshot_revs = st.total_revs;
         st.event_counter = '0;
      end else begin
         st.event_counter = st.event_counter + 6'd1;
      end
      if (count != st.prev_count) begin
         drev = 64'(16'(count - st.prev_count));
         dtime = 64'(16'(ev_time - st.prev_time));
         st.total_revs = st.total_revs + drev[31:0];
         st.prev_count = count;
         st.prev_time = ev_time;
         value = '0;
         if (dtime != 0) begin
            if (ch == CHAN_WHEEL) begin
               value = (64'(cfg.wheel_circumference_mm) * SPEED_SCALE * drev) /
                       (dtime * SPEED_DIVISOR);
            end else begin
               value = (CADENCE_SCALE * drev) / dtime;
            end
         end
         st.held_value = (value > 64'(limit)) ? 8'd0 : value[7:0];
      end
      // stalled: no revolutions since the last snapshot
      if (st.snapshot_revs == st.total_revs && st.total_revs != 0) st.held_value = '0;
      if (st.held_value > limit) st.held_value = '0;
      chan_state[ch] = st;
      return st.held_value;
   endfunction

   always @(posedge clock) begin : monitor
      reading_type exp_r;
      reading_type got_r;
      if (reset) begin
         cfg.wheel_circumference_mm = RST_WHEEL_CIRC;
         cfg.stale_events = RST_STALE_EVENTS;
         cfg.speed_limit_kph = RST_SPEED_LIMIT;
         cfg.cadence_limit_rpm = RST_CADENCE_LIMIT;
         for (int ch = 0; ch < NUM_CHAN; ch++) chan_state[ch] = '0;
         expected_readings.delete();
         fail_tally = 0;
         mismatch_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_WHEEL_CIRC: cfg.wheel_circumference_mm = csr_wdata[11:0];
               CSR_STALE_EVENTS: cfg.stale_events = csr_wdata[5:0];
               CSR_SPEED_LIMIT: cfg.speed_limit_kph = csr_wdata[7:0];
               CSR_CADENCE_LIMIT: cfg.cadence_limit_rpm = csr_wdata[7:0];
               default: ;
            endcase
         end
         // result side first so a beat never matches an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got_r = rsp_tdata;
            if (expected_readings.size() == 0) begin
               fail_tally++;
               if (fail_tally <= REPORT_LIMIT)
                  $display("unexpected result beat: speed %0d cadence %0d",
                           got_r.speed_kph, got_r.cadence_rpm);
            end else begin
               exp_r = expected_readings.pop_front();
               if (got_r.speed_kph !== exp_r.speed_kph ||
                   got_r.cadence_rpm !== exp_r.cadence_rpm) begin
                  fail_tally++;
                  if (fail_tally <= REPORT_LIMIT)
                     $display("reading mismatch: speed exp %0d got %0d, cadence exp %0d got %0d",
                              exp_r.speed_kph, got_r.speed_kph,
                              exp_r.cadence_rpm, got_r.cadence_rpm);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            exp_r.speed_kph = advance_channel(CHAN_WHEEL, req_tdata[15:0], req_tdata[31:16]);
            exp_r.cadence_rpm = advance_channel(CHAN_CRANK, req_tdata[47:32], req_tdata[63:48]);
            expected_readings.push_back(exp_r);
         end
         mismatch_count <= fail_tally;
         pending_count <= expected_readings.size();
      end
   end

endmodule

// ----- tb/sv/tb_wheel_speed_and_cadence_calc.sv -----
`timescale 1ns / 1ps
module tb_wheel_speed_and_cadence_calc;
   import wsc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // wheel_rev_count, wheel_event_time, crank_rev_count, crank_event_time
   logic [63:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // speed_kph, cadence_rpm
   logic [15:0] rsp_tdata;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_count;
   int cycle_count;
   int hold_off_left;
   bit full_rate;

   // simulated rider, one count and event time per channel
   logic [15:0] wheel_cnt, wheel_tm, crank_cnt, crank_tm;
   int wheel_period, crank_period;
   bit wheel_frozen, crank_frozen;
   int seg_left;

   wheel_speed_and_cadence_calc DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   wsc_reading_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] pack_item(input logic [15:0] wc, input logic [15:0] wt,
                                             input logic [15:0] cc, input logic [15:0] ct);
      return {ct, cc, wt, wc};
   endfunction

   function automatic int pick_period();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(150, 1200);
      else if (r < 8) return $urandom_range(15, 150);
      else return $urandom_range(1200, 40000);
   endfunction

   task automatic step_rider(inout logic [15:0] cnt, inout logic [15:0] ev_t,
                             input int period, input bit frozen);
      int drev;
      int k;
      k = $urandom_range(0, 9);
      if (frozen || k < 3) drev = 0;
      else if (k < 8) drev = 1;
      else if (k == 8) drev = 2;
      else drev = $urandom_range(3, 20);
      if (drev > 0) begin
         cnt = cnt + 16'(drev);
         if ($urandom_range(0, 39) != 0)
            ev_t = ev_t + 16'(drev * period + $urandom_range(0, period / 8));
      end else if ($urandom_range(0, 19) == 0) begin
         ev_t = 16'($urandom);
      end
   endtask

   task automatic send_item(input logic [63:0] item);
      int gap;
      int r;
      req_tvalid <= 1'b1;
      req_tdata <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = $urandom_range(0, 99);
      if (full_rate || r < 45) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // upper bits beyond the register width carry junk
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int value, input int width);
      logic [CSR_DATA_W-1:0] junk;
      logic [CSR_DATA_W-1:0] field;
      junk = CSR_DATA_W'($urandom);
      field = CSR_DATA_W'(value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= (junk << width) | field;
      @(posedge clock);
   endtask

   task automatic set_config(input int circ, input int stale, input int speed_lim,
                             input int cadence_lim);
      write_reg(CSR_WHEEL_CIRC, circ, 12);
      write_reg(CSR_STALE_EVENTS, stale, 6);
      write_reg(CSR_SPEED_LIMIT, speed_lim, 8);
      write_reg(CSR_CADENCE_LIMIT, cadence_lim, 8);
      csr_we <= 1'b0;
   endtask

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("wheel_speed_and_cadence_calc verification failed");
      $finish;
   end

   initial begin : receiver
      int run_left;
      int r;
      bit ready_level;
      run_left = 0;
      ready_level = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else begin
            if (run_left == 0) begin
               r = $urandom_range(0, 9);
               if (full_rate) begin
                  ready_level = 1'b1;
                  run_left = 1;
               end else if (r < 6) begin
                  ready_level = 1'b1;
                  run_left = $urandom_range(1, 12);
               end else if (r < 9) begin
                  ready_level = 1'b0;
                  run_left = $urandom_range(1, 3);
               end else begin
                  ready_level = 1'b0;
                  run_left = $urandom_range(10, 40);
               end
            end
            rsp_tready <= ready_level;
            run_left--;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] item;
      int phase;
      int i;
      hold_off_left = 0;
      full_rate = 1'b0;
      wheel_cnt = '0;
      wheel_tm = '0;
      crank_cnt = '0;
      crank_tm = '0;
      wheel_period = 300;
      crank_period = 600;
      wheel_frozen = 1'b0;
      crank_frozen = 1'b0;
      seg_left = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      send_item(pack_item(16'd0, 16'd0, 16'd0, 16'd0));
      send_item(pack_item(16'd1, 16'd256, 16'd1, 16'd512));
      send_item(pack_item(16'd2, 16'd256, 16'd2, 16'd1012));
      send_item(pack_item(16'd3, 16'd320, 16'd3, 16'd1524));
      send_item(pack_item(16'd3, 16'd999, 16'd3, 16'd7));
      send_item(pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(pack_item(16'd1, 16'd255, 16'd0, 16'd511));
      send_item(pack_item(16'd2, 16'd555, 16'd1, 16'd1111));
      // held values above lowered limits
      drain_results();
      write_reg(CSR_SPEED_LIMIT, 20, 8);
      write_reg(CSR_CADENCE_LIMIT, 100, 8);
      csr_we <= 1'b0;
      send_item(pack_item(16'd2, 16'd555, 16'd1, 16'd1111));
      drain_results();
      write_reg(CSR_SPEED_LIMIT, 255, 8);
      write_reg(CSR_CADENCE_LIMIT, 255, 8);
      csr_we <= 1'b0;
      send_item(pack_item(16'd3, 16'd600, 16'd2, 16'd1400));
      send_item(pack_item(16'd4, 16'd600, 16'd3, 16'd1400));
      send_item(pack_item(16'd5, 16'd1000, 16'd4, 16'd1700));
      // snapshot on every item
      drain_results();
      write_reg(CSR_STALE_EVENTS, 0, 6);
      csr_we <= 1'b0;
      send_item(pack_item(16'd6, 16'd1300, 16'd5, 16'd2000));
      send_item(pack_item(16'd6, 16'd1300, 16'd5, 16'd2000));
      send_item(pack_item(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: set_config(4095, 63, 255, 255);
            1: set_config(0, 0, 255, 0);
            2: set_config(4095, 1, 0, 255);
            3: set_config(2130, 63, 120, 120);
            default: set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(1000, 2600),
                                $urandom_range(0, 63),
                                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(60, 255),
                                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(60, 255));
         endcase
         full_rate = (phase == 4);
         if (phase == 1) hold_off_left = HOLD_OFF_CYCLES;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // event counter left above a lowered stale_events
            if (phase == 3 && i == PHASE_ITEMS / 2) begin
               drain_results();
               write_reg(CSR_STALE_EVENTS, 2, 6);
               write_reg(CSR_SPEED_LIMIT, 25, 8);
               write_reg(CSR_CADENCE_LIMIT, 40, 8);
               csr_we <= 1'b0;
            end
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 80);
               wheel_period = pick_period();
               crank_period = pick_period();
               wheel_frozen = ($urandom_range(0, 4) == 0);
               crank_frozen = ($urandom_range(0, 4) == 0);
               if ($urandom_range(0, 3) == 0) begin
                  wheel_cnt = 16'($urandom);
                  wheel_tm = 16'($urandom);
               end
               if ($urandom_range(0, 3) == 0) begin
                  crank_cnt = 16'($urandom);
                  crank_tm = 16'($urandom);
               end
            end
            seg_left--;
            if ($urandom_range(0, 99) < 8) begin
               item = {$urandom, $urandom};
            end else begin
               step_rider(wheel_cnt, wheel_tm, wheel_period, wheel_frozen);
               step_rider(crank_cnt, crank_tm, crank_period, crank_frozen);
               item = pack_item(wheel_cnt, wheel_tm, crank_cnt, crank_tm);
            end
            send_item(item);
         end
      end
      full_rate = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("wheel_speed_and_cadence_calc verification clean");
      end else begin
         $display("wheel_speed_and_cadence_calc verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/wsc_pkg.sv
rtl/core/wsc_front.sv
rtl/core/wsc_queue.sv
rtl/core/wsc_back.sv
rtl/core/wheel_speed_and_cadence_calc.sv
tb/sv/wsc_reading_checker.sv
tb/sv/tb_wheel_speed_and_cadence_calc.sv
